// ===== rtl/core/dta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dta_pkg
// Shared widths, constants, sideband types and the CORDIC arctangent table
// for the direction to axis-angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dta_pkg;

    localparam int A_W      = 24;  // normalised magnitude width
    localparam int SQ_W     = 48;  // one square
    localparam int SUM_W    = 50;  // sum of up to three squares
    localparam int NSQ_W    = 64;  // radicand for the length
    localparam int LEN_W    = 32;  // length root
    localparam int PERP_W   = 25;  // root of the perpendicular part
    localparam int DIV_W    = 48;  // divider remainder
    localparam int Q_W      = 16;  // quotient
    localparam int XY_W     = 28;  // CORDIC x and y
    localparam int Z_W      = 26;  // CORDIC angle, degrees with 16 fraction bits
    localparam int ATAN_LEN = 24;

    localparam logic [Q_W-1:0]          UNIT_ONE  = 16'd16384;
    localparam logic [15:0]             ANGLE_MAX = 16'd46080;
    localparam logic signed [Z_W-1:0]   Z_RIGHT   = 26'sd5898240;  // 90 degrees

    typedef struct packed {
        logic [SUM_W-1:0] perp_sq;
        logic [A_W-1:0]   a;
        logic [A_W-1:0]   b;
        logic [A_W-1:0]   c;
        logic [2:0]       neg;
        logic             zero;
    } lside_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [A_W-1:0]   a;
        logic [A_W-1:0]   b;
        logic [A_W-1:0]   c;
        logic [2:0]       neg;
        logic             zero;
    } pside_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [2:0]             neg;
        logic                   zero;
    } dside_t;

    typedef struct packed {
        logic [2:0][Q_W-1:0] q;
        logic [2:0]          neg;
        logic                zero;
    } cside_t;

    // atan(2^-k) in degrees, 16 fraction bits
    function automatic logic [21:0] atan_deg16(input int k);
        logic [21:0] v;
        case (k)
            0:       v = 22'd2949120;
            1:       v = 22'd1740967;
            2:       v = 22'd919879;
            3:       v = 22'd466945;
            4:       v = 22'd234379;
            5:       v = 22'd117304;
            6:       v = 22'd58666;
            7:       v = 22'd29335;
            8:       v = 22'd14668;
            9:       v = 22'd7334;
            10:      v = 22'd3667;
            11:      v = 22'd1833;
            12:      v = 22'd917;
            13:      v = 22'd458;
            14:      v = 22'd229;
            15:      v = 22'd115;
            16:      v = 22'd57;
            17:      v = 22'd29;
            18:      v = 22'd14;
            19:      v = 22'd7;
            20:      v = 22'd4;
            21:      v = 22'd2;
            22:      v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/direction_to_axis_angle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_to_axis_angle
// Direction between two points, normalised, as the rotation taking +x onto it.
// ----------------------------------------------------------------------------
//  channel | ports                          | transfer
//  --------+--------------------------------+---------------------------
//  input   | s_valid s_ready s_cur_* s_nxt_*| s_valid & s_ready
//  result  | m_valid m_ready m_angle_deg ...| m_valid & m_ready
//
//  One point pair per cycle while results are taken. The pipeline depth is set
//  by the 32-cell and 25-cell root chains, the 16-cell divider chain and the
//  CORDIC chain.
//  Whole pipeline advances together; it stalls only while a result sits in
//  the output register untaken. Reset (synchronous, active low) clears valids.
// ----------------------------------------------------------------------------
`default_nettype none

module direction_to_axis_angle #(
    parameter int COORD_WIDTH   = 24,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_WIDTH-1:0] s_cur_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_cur_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_cur_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_nxt_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_nxt_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_nxt_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [15:0]                        m_angle_deg,
    output logic signed [15:0]                 m_unit_dx,
    output logic signed [15:0]                 m_axis_y,
    output logic signed [15:0]                 m_axis_z,
    output logic                               m_zero_length
);

    localparam int MW   = COORD_WIDTH + 1;
    localparam int PBW  = $clog2(MW);
    localparam int NST  = (CORDIC_STAGES > dta_pkg::ATAN_LEN) ?
                          dta_pkg::ATAN_LEN : CORDIC_STAGES;
    localparam int A_W  = dta_pkg::A_W;
    localparam int LEN_W  = dta_pkg::LEN_W;
    localparam int PERP_W = dta_pkg::PERP_W;
    localparam int Q_W  = dta_pkg::Q_W;
    localparam int LPW  = $bits(dta_pkg::lside_t);
    localparam int PPW  = $bits(dta_pkg::pside_t);
    localparam int DPW  = $bits(dta_pkg::dside_t);
    localparam int CPW  = $bits(dta_pkg::cside_t);

    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---- stage 0: differences and magnitudes
    logic signed [MW-1:0] d_next [3];
    logic [2:0][MW-1:0]   mag_next;
    logic [2:0]           neg_next;
    logic                 v0_reg;
    logic [2:0][MW-1:0]   mag0_reg;
    logic [2:0]           neg0_reg;

    always_comb begin
        d_next[0] = MW'(s_nxt_x) - MW'(s_cur_x);
        d_next[1] = MW'(s_nxt_y) - MW'(s_cur_y);
        d_next[2] = MW'(s_nxt_z) - MW'(s_cur_z);
        for (int l = 0; l < 3; l++) begin
            neg_next[l] = d_next[l][MW-1];
            mag_next[l] = neg_next[l] ? MW'(-d_next[l]) : MW'(d_next[l]);
        end
    end

    // ---- stage 1: largest magnitude and its leading one
    logic [MW-1:0]      mx;
    logic [PBW-1:0]     msb_next;
    logic               v1_reg;
    logic [2:0][MW-1:0] mag1_reg;
    logic [2:0]         neg1_reg;
    logic [PBW-1:0]     msb1_reg;
    logic               zero1_reg;

    always_comb begin
        mx = mag0_reg[0];
        if (mag0_reg[1] > mx) mx = mag0_reg[1];
        if (mag0_reg[2] > mx) mx = mag0_reg[2];
        msb_next = '0;
        for (int j = 0; j < MW; j++) begin
            if (mx[j]) msb_next = PBW'(j);
        end
    end

    // ---- stage 2: common shift so the largest has its top bit at A_W-1
    logic [MW+A_W-2:0]   ext [3];
    logic [2:0][A_W-1:0] nrm_next;
    logic                v2_reg;
    logic [2:0][A_W-1:0] nrm2_reg;
    logic [2:0]          neg2_reg;
    logic                zero2_reg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            ext[l]      = {mag1_reg[l], {(A_W-1){1'b0}}} >> msb1_reg;
            nrm_next[l] = ext[l][A_W-1:0];
        end
    end

    // ---- stage 3: squares
    logic                          v3_reg;
    logic [2:0][dta_pkg::SQ_W-1:0] sq3_reg;
    logic [2:0][A_W-1:0]           nrm3_reg;
    logic [2:0]                    neg3_reg;
    logic                          zero3_reg;

    // ---- stage 4: sums
    logic                           v4_reg;
    logic [dta_pkg::NSQ_W-1:0]      nsq4_reg;
    dta_pkg::lside_t                lside4_reg;
    logic [dta_pkg::SUM_W-1:0]      sum_all;

    assign sum_all = dta_pkg::SUM_W'(sq3_reg[0]) + dta_pkg::SUM_W'(sq3_reg[1])
                   + dta_pkg::SUM_W'(sq3_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag0_reg  <= mag_next;
            neg0_reg  <= neg_next;
            mag1_reg  <= mag0_reg;
            neg1_reg  <= neg0_reg;
            msb1_reg  <= msb_next;
            zero1_reg <= (mx == '0);
            nrm2_reg  <= nrm_next;
            neg2_reg  <= neg1_reg;
            zero2_reg <= zero1_reg;
            for (int l = 0; l < 3; l++) begin
                sq3_reg[l] <= nrm2_reg[l] * nrm2_reg[l];
            end
            nrm3_reg  <= nrm2_reg;
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
            nsq4_reg  <= {sum_all, 14'b0};
            lside4_reg.perp_sq <= dta_pkg::SUM_W'(sq3_reg[1]) + dta_pkg::SUM_W'(sq3_reg[2]);
            lside4_reg.a    <= nrm3_reg[0];
            lside4_reg.b    <= nrm3_reg[1];
            lside4_reg.c    <= nrm3_reg[2];
            lside4_reg.neg  <= neg3_reg;
            lside4_reg.zero <= zero3_reg;
        end
    end

    // ---- length root chain
    logic                      ls_vld  [LEN_W+1];
    logic [dta_pkg::NSQ_W-1:0] ls_rem  [LEN_W+1];
    logic [LEN_W-1:0]          ls_root [LEN_W+1];
    logic [LPW-1:0]            ls_side [LEN_W+1];

    assign ls_vld[0]  = v4_reg;
    assign ls_rem[0]  = nsq4_reg;
    assign ls_root[0] = '0;
    assign ls_side[0] = lside4_reg;

    for (genvar g = 0; g < LEN_W; g++) begin : g_len
        dta_sqrt_cell #(
            .NW(dta_pkg::NSQ_W), .RW(LEN_W), .I(LEN_W - 1 - g), .PW(LPW)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .vld_in(ls_vld[g]), .rem_in(ls_rem[g]), .root_in(ls_root[g]),
            .side_in(ls_side[g]),
            .vld_out(ls_vld[g+1]), .rem_out(ls_rem[g+1]), .root_out(ls_root[g+1]),
            .side_out(ls_side[g+1])
        );
    end

    // ---- perpendicular root chain
    dta_pkg::lside_t           ls_last;
    dta_pkg::pside_t           ps_first;
    logic                      ps_vld  [PERP_W+1];
    logic [dta_pkg::SUM_W-1:0] ps_rem  [PERP_W+1];
    logic [PERP_W-1:0]         ps_root [PERP_W+1];
    logic [PPW-1:0]            ps_side [PERP_W+1];

    always_comb begin
        ls_last       = ls_side[LEN_W];
        ps_first.len  = ls_root[LEN_W];
        ps_first.a    = ls_last.a;
        ps_first.b    = ls_last.b;
        ps_first.c    = ls_last.c;
        ps_first.neg  = ls_last.neg;
        ps_first.zero = ls_last.zero;
    end

    assign ps_vld[0]  = ls_vld[LEN_W];
    assign ps_rem[0]  = ls_last.perp_sq;
    assign ps_root[0] = '0;
    assign ps_side[0] = ps_first;

    for (genvar g = 0; g < PERP_W; g++) begin : g_perp
        dta_sqrt_cell #(
            .NW(dta_pkg::SUM_W), .RW(PERP_W), .I(PERP_W - 1 - g), .PW(PPW)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .vld_in(ps_vld[g]), .rem_in(ps_rem[g]), .root_in(ps_root[g]),
            .side_in(ps_side[g]),
            .vld_out(ps_vld[g+1]), .rem_out(ps_rem[g+1]), .root_out(ps_root[g+1]),
            .side_out(ps_side[g+1])
        );
    end

    // ---- stage 5: dividends and CORDIC start vector
    dta_pkg::pside_t                 ps_last;
    logic [2:0][dta_pkg::DIV_W-1:0]  num_next;
    logic [2:0][A_W-1:0]             m_lane;
    logic signed [dta_pkg::XY_W-1:0] ax;
    logic signed [dta_pkg::XY_W-1:0] py;
    dta_pkg::dside_t                 dside_next;
    logic                            v5_reg;
    logic [LEN_W-1:0]                len5_reg;
    logic [2:0][dta_pkg::DIV_W-1:0]  num5_reg;
    dta_pkg::dside_t                 dside5_reg;

    always_comb begin
        ps_last   = ps_side[PERP_W];
        m_lane[0] = ps_last.a;
        m_lane[1] = ps_last.b;
        m_lane[2] = ps_last.c;
        for (int l = 0; l < 3; l++) begin
            num_next[l] = dta_pkg::DIV_W'({m_lane[l], 21'b0})
                        + dta_pkg::DIV_W'(ps_last.len >> 1);
        end
        ax = $signed(dta_pkg::XY_W'(ps_last.a));
        py = $signed(dta_pkg::XY_W'(ps_root[PERP_W]));
        dside_next.neg  = ps_last.neg;
        dside_next.zero = ps_last.zero;
        // negative x: pre-rotate by -90 degrees
        if (ps_last.neg[0] && (ps_last.a != '0)) begin
            dside_next.x = py;
            dside_next.y = ax;
            dside_next.z = dta_pkg::Z_RIGHT;
        end else begin
            dside_next.x = ax;
            dside_next.y = py;
            dside_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= ps_vld[PERP_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len5_reg   <= ps_last.len;
            num5_reg   <= num_next;
            dside5_reg <= dside_next;
        end
    end

    // ---- divider chain
    logic                           dv_vld  [Q_W+1];
    logic [LEN_W-1:0]               dv_den  [Q_W+1];
    logic [2:0][dta_pkg::DIV_W-1:0] dv_rem  [Q_W+1];
    logic [2:0][Q_W-1:0]            dv_q    [Q_W+1];
    logic [DPW-1:0]                 dv_side [Q_W+1];

    assign dv_vld[0]  = v5_reg;
    assign dv_den[0]  = len5_reg;
    assign dv_rem[0]  = num5_reg;
    assign dv_q[0]    = '0;
    assign dv_side[0] = dside5_reg;

    for (genvar g = 0; g < Q_W; g++) begin : g_div
        dta_div_cell #(
            .DW(dta_pkg::DIV_W), .LW(LEN_W), .QW(Q_W), .I(Q_W - 1 - g), .PW(DPW)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .vld_in(dv_vld[g]), .den_in(dv_den[g]), .rem_in(dv_rem[g]),
            .q_in(dv_q[g]), .side_in(dv_side[g]),
            .vld_out(dv_vld[g+1]), .den_out(dv_den[g+1]), .rem_out(dv_rem[g+1]),
            .q_out(dv_q[g+1]), .side_out(dv_side[g+1])
        );
    end

    // ---- CORDIC chain
    dta_pkg::dside_t                 dv_last;
    dta_pkg::cside_t                 cs_first;
    logic                            cr_vld  [NST+1];
    logic signed [dta_pkg::XY_W-1:0] cr_x    [NST+1];
    logic signed [dta_pkg::XY_W-1:0] cr_y    [NST+1];
    logic signed [dta_pkg::Z_W-1:0]  cr_z    [NST+1];
    logic [CPW-1:0]                  cr_side [NST+1];

    always_comb begin
        dv_last       = dv_side[Q_W];
        cs_first.q    = dv_q[Q_W];
        cs_first.neg  = dv_last.neg;
        cs_first.zero = dv_last.zero;
    end

    assign cr_vld[0]  = dv_vld[Q_W];
    assign cr_x[0]    = dv_last.x;
    assign cr_y[0]    = dv_last.y;
    assign cr_z[0]    = dv_last.z;
    assign cr_side[0] = cs_first;

    for (genvar g = 0; g < NST; g++) begin : g_cordic
        dta_cordic_cell #(.K(g), .PW(CPW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .vld_in(cr_vld[g]), .x_in(cr_x[g]), .y_in(cr_y[g]), .z_in(cr_z[g]),
            .side_in(cr_side[g]),
            .vld_out(cr_vld[g+1]), .x_out(cr_x[g+1]), .y_out(cr_y[g+1]),
            .z_out(cr_z[g+1]), .side_out(cr_side[g+1])
        );
    end

    // ---- output stage: round, saturate, sign, zero-length mask
    dta_pkg::cside_t             cs_last;
    logic [dta_pkg::Z_W-1:0]     z_sum;
    logic [dta_pkg::Z_W-9:0]     z_rnd;
    logic [15:0]                 ang_next;
    logic [2:0][Q_W-1:0]         qs;
    logic [15:0]                 angle_reg;
    logic signed [15:0]          unit_dx_reg;
    logic signed [15:0]          axis_y_reg;
    logic signed [15:0]          axis_z_reg;
    logic                        zero_reg;

    always_comb begin
        cs_last = cr_side[NST];
        z_sum   = (cr_z[NST] < 0) ? dta_pkg::Z_W'(128)
                                  : dta_pkg::Z_W'(cr_z[NST]) + dta_pkg::Z_W'(128);
        z_rnd   = z_sum[dta_pkg::Z_W-1:8];
        ang_next = (z_rnd > (dta_pkg::Z_W-8)'(dta_pkg::ANGLE_MAX)) ?
                   dta_pkg::ANGLE_MAX : z_rnd[15:0];
        for (int l = 0; l < 3; l++) begin
            qs[l] = (cs_last.q[l] > dta_pkg::UNIT_ONE) ? dta_pkg::UNIT_ONE : cs_last.q[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cr_vld[NST];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg <= cs_last.zero;
            if (cs_last.zero) begin
                angle_reg   <= '0;
                unit_dx_reg <= '0;
                axis_y_reg  <= '0;
                axis_z_reg  <= '0;
            end else begin
                angle_reg   <= ang_next;
                unit_dx_reg <= cs_last.neg[0] ? -$signed(qs[0]) : $signed(qs[0]);
                axis_y_reg  <= cs_last.neg[2] ? $signed(qs[2]) : -$signed(qs[2]);
                axis_z_reg  <= cs_last.neg[1] ? -$signed(qs[1]) : $signed(qs[1]);
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_angle_deg   = angle_reg;
    assign m_unit_dx     = unit_dx_reg;
    assign m_axis_y      = axis_y_reg;
    assign m_axis_z      = axis_z_reg;
    assign m_zero_length = zero_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dta_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dta_sqrt_cell
// One root bit of a restoring integer square root, with passenger data.
// ----------------------------------------------------------------------------
`default_nettype none

module dta_sqrt_cell #(
    parameter int NW = 64,
    parameter int RW = 32,
    parameter int I  = 0,
    parameter int PW = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          vld_in,
    input  wire logic [NW-1:0] rem_in,
    input  wire logic [RW-1:0] root_in,
    input  wire logic [PW-1:0] side_in,
    output logic               vld_out,
    output logic [NW-1:0]      rem_out,
    output logic [RW-1:0]      root_out,
    output logic [PW-1:0]      side_out
);

    logic [NW:0]   test;
    logic          fits;
    logic [NW-1:0] rem_next;
    logic [RW-1:0] root_next;
    logic          vld_reg;
    logic [NW-1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [PW-1:0] side_reg;

    // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i); r has no bits below i+1
    always_comb begin
        test      = ((NW+1)'(root_in) << (I + 1)) | ((NW+1)'(1) << (2 * I));
        fits      = {1'b0, rem_in} >= test;
        rem_next  = fits ? NW'({1'b0, rem_in} - test) : rem_in;
        root_next = fits ? (root_in | (RW'(1) << I)) : root_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dta_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dta_div_cell
// One quotient bit of a restoring divide for three lanes sharing a divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module dta_div_cell #(
    parameter int DW = 48,
    parameter int LW = 32,
    parameter int QW = 16,
    parameter int I  = 0,
    parameter int PW = 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                vld_in,
    input  wire logic [LW-1:0]       den_in,
    input  wire logic [2:0][DW-1:0]  rem_in,
    input  wire logic [2:0][QW-1:0]  q_in,
    input  wire logic [PW-1:0]       side_in,
    output logic                     vld_out,
    output logic [LW-1:0]            den_out,
    output logic [2:0][DW-1:0]       rem_out,
    output logic [2:0][QW-1:0]       q_out,
    output logic [PW-1:0]            side_out
);

    logic [DW-1:0]      dsh;
    logic [2:0][DW-1:0] rem_next;
    logic [2:0][QW-1:0] q_next;
    logic               vld_reg;
    logic [LW-1:0]      den_reg;
    logic [2:0][DW-1:0] rem_reg;
    logic [2:0][QW-1:0] q_reg;
    logic [PW-1:0]      side_reg;

    always_comb begin
        dsh = DW'(den_in) << I;
        for (int l = 0; l < 3; l++) begin
            if (rem_in[l] >= dsh) begin
                rem_next[l] = rem_in[l] - dsh;
                q_next[l]   = q_in[l] | (QW'(1) << I);
            end else begin
                rem_next[l] = rem_in[l];
                q_next[l]   = q_in[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg  <= den_in;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dta_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dta_cordic_cell
// One vectoring CORDIC micro-rotation with a fixed shift, angle in degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module dta_cordic_cell #(
    parameter int K  = 0,
    parameter int PW = 1
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               en,
    input  wire logic                               vld_in,
    input  wire logic signed [dta_pkg::XY_W-1:0]    x_in,
    input  wire logic signed [dta_pkg::XY_W-1:0]    y_in,
    input  wire logic signed [dta_pkg::Z_W-1:0]     z_in,
    input  wire logic [PW-1:0]                      side_in,
    output logic                                    vld_out,
    output logic signed [dta_pkg::XY_W-1:0]         x_out,
    output logic signed [dta_pkg::XY_W-1:0]         y_out,
    output logic signed [dta_pkg::Z_W-1:0]          z_out,
    output logic [PW-1:0]                           side_out
);

    localparam logic signed [dta_pkg::Z_W-1:0] ATAN =
        dta_pkg::Z_W'(dta_pkg::atan_deg16(K));

    logic signed [dta_pkg::XY_W-1:0] xs;
    logic signed [dta_pkg::XY_W-1:0] ys;
    logic signed [dta_pkg::XY_W-1:0] x_next;
    logic signed [dta_pkg::XY_W-1:0] y_next;
    logic signed [dta_pkg::Z_W-1:0]  z_next;
    logic                            vld_reg;
    logic signed [dta_pkg::XY_W-1:0] x_reg;
    logic signed [dta_pkg::XY_W-1:0] y_reg;
    logic signed [dta_pkg::Z_W-1:0]  z_reg;
    logic [PW-1:0]                   side_reg;

    always_comb begin
        xs = x_in >>> K;
        ys = y_in >>> K;
        if (y_in > 0) begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end else begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dta_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dta_chk
// Port-level checks on the result channel of direction_to_axis_angle.
// ----------------------------------------------------------------------------
`default_nettype none

module dta_chk (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [15:0]        m_angle_deg,
    input wire logic signed [15:0] m_unit_dx,
    input wire logic signed [15:0] m_axis_y,
    input wire logic signed [15:0] m_axis_z,
    input wire logic               m_zero_length
);

    // held result stays put until its transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_angle_deg)
            && $stable(m_unit_dx) && $stable(m_axis_y) && $stable(m_axis_z)
            && $stable(m_zero_length))
        else $error("result changed while stalled");

    // an empty output register never blocks the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result waiting");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_length |-> m_angle_deg == 16'd0 && m_unit_dx == 16'sd0
            && m_axis_y == 16'sd0 && m_axis_z == 16'sd0)
        else $error("zero-length result not cleared");

    a_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_angle_deg <= 16'd46080)
        else $error("angle out of range");

    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_unit_dx >= -16'sd16384 && m_unit_dx <= 16'sd16384
            && m_axis_y >= -16'sd16384 && m_axis_y <= 16'sd16384
            && m_axis_z >= -16'sd16384 && m_axis_z <= 16'sd16384)
        else $error("unit component out of range");

endmodule

bind direction_to_axis_angle dta_chk u_dta_chk (.*);

`default_nettype wire

// ===== bench/tb_direction_to_axis_angle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direction_to_axis_angle
// Drives point pairs into the direction to axis-angle pipeline under random
// idling and back-pressure, and checks every result against a local
// fixed-point predictor of the normalisation, the roots and the CORDIC angle.
// ----------------------------------------------------------------------------

module tb_direction_to_axis_angle;

    localparam int CW      = 24;
    localparam int STAGES  = 16;
    localparam int LATENCY = 120;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [15:0] angle;
        logic [15:0] udx;
        logic [15:0] ay;
        logic [15:0] az;
        logic        zl;
    } rot_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_cur_x = '0, s_cur_y = '0, s_cur_z = '0;
    logic signed [CW-1:0] s_nxt_x = '0, s_nxt_y = '0, s_nxt_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_angle_deg;
    logic signed [15:0] m_unit_dx, m_axis_y, m_axis_z;
    logic m_zero_length;

    rot_t rot_queue[$];
    int   n_errors = 0;
    int   n_results = 0;
    longint cycles = 0;
    bit   src_idle_on = 1'b1;
    bit   sink_idle_on = 1'b1;
    bit   sink_hold = 1'b0;

    direction_to_axis_angle #(.COORD_WIDTH(CW), .CORDIC_STAGES(STAGES)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cur_x(s_cur_x), .s_cur_y(s_cur_y), .s_cur_z(s_cur_z),
        .s_nxt_x(s_nxt_x), .s_nxt_y(s_nxt_y), .s_nxt_z(s_nxt_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_angle_deg(m_angle_deg), .m_unit_dx(m_unit_dx), .m_axis_y(m_axis_y),
        .m_axis_z(m_axis_z), .m_zero_length(m_zero_length)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint atan_step(input int k);
        longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[k];
    endfunction

    function automatic rot_t predict_rotation(input logic signed [CW-1:0] c[3],
                                              input logic signed [CW-1:0] n[3]);
        rot_t r;
        longint d[3];
        longint unsigned mag[3], mx, len, perp, q;
        longint u[3], x, y, z, xs, ys, t;
        int st;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(n[i]) - longint'(c[i]);
            mag[i] = d[i] < 0 ? -d[i] : d[i];
        end
        if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
            r.angle = 0; r.udx = 0; r.ay = 0; r.az = 0; r.zl = 1'b1;
            return r;
        end
        mx = mag[0];
        if (mag[1] > mx) mx = mag[1];
        if (mag[2] > mx) mx = mag[2];
        while (mx >= (64'd1 << 24)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (mx < (64'd1 << 23)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        len = int_sqrt((mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]) << 14);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 21) + (len >> 1)) / len;
            if (q > 16384) q = 16384;
            u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
        end
        perp = int_sqrt(mag[1] * mag[1] + mag[2] * mag[2]);
        x = d[0] < 0 ? -longint'(mag[0]) : longint'(mag[0]);
        y = perp;
        z = 0;
        if (x < 0) begin
            t = x; x = y; y = -t; z = 90 * 65536;
        end
        st = STAGES > 24 ? 24 : STAGES;
        for (int k = 0; k < st; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y > 0) begin
                x += ys; y -= xs; z += atan_step(k);
            end else begin
                x -= ys; y += xs; z -= atan_step(k);
            end
        end
        if (z < 0) z = 0;
        z = (z + 128) >>> 8;
        if (z > 46080) z = 46080;
        r.angle = z[15:0];
        r.udx = u[0][15:0];
        r.ay = 16'(-u[2]);
        r.az = u[1][15:0];
        r.zl = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        n_errors++;
        $display("MISMATCH result %0d %s: got %0h, expected %0h", n_results, what,
                 got, want);
    endtask

    // result checker and sink-side idling
    always @(posedge aclk) begin
        rot_t e;
        if (aresetn && m_valid && m_ready) begin
            if (rot_queue.size() == 0) begin
                n_errors++;
                $display("MISMATCH unexpected result transfer");
            end else begin
                e = rot_queue.pop_front();
                if (m_angle_deg !== e.angle) report_mismatch("angle", m_angle_deg, e.angle);
                if (m_unit_dx !== e.udx) report_mismatch("unit_dx", m_unit_dx, e.udx);
                if (m_axis_y !== e.ay) report_mismatch("axis_y", m_axis_y, e.ay);
                if (m_axis_z !== e.az) report_mismatch("axis_z", m_axis_z, e.az);
                if (m_zero_length !== e.zl)
                    report_mismatch("zero_length", m_zero_length, e.zl);
            end
            n_results++;
        end
    end

    initial begin : sink
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (sink_hold) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 24);
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic send_pair(input logic signed [CW-1:0] c[3],
                             input logic signed [CW-1:0] n[3]);
        int gap;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cur_x <= c[0]; s_cur_y <= c[1]; s_cur_z <= c[2];
        s_nxt_x <= n[0]; s_nxt_y <= n[1]; s_nxt_z <= n[2];
        rot_queue.push_back(predict_rotation(c, n));
        @(posedge aclk iff s_ready);
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return -(24'sd1 <<< 23);
            1: return (24'sd1 <<< 23) - 1;
            2: return CW'($signed($urandom_range(0, 64)) - 32);
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic send_offset(input logic signed [CW-1:0] c[3], input longint dx,
                               input longint dy, input longint dz);
        logic signed [CW-1:0] n[3];
        n[0] = CW'(c[0] + dx); n[1] = CW'(c[1] + dy); n[2] = CW'(c[2] + dz);
        send_pair(c, n);
    endtask

    task automatic test_directed();
        logic signed [CW-1:0] o[3], mn[3], mxv[3];
        o = '{0, 0, 0};
        mn = '{-(24'sd1 <<< 23), -(24'sd1 <<< 23), -(24'sd1 <<< 23)};
        mxv = '{(24'sd1 <<< 23) - 1, (24'sd1 <<< 23) - 1, (24'sd1 <<< 23) - 1};
        send_pair(o, o);                  // coincident points
        send_pair(mn, mn);
        send_pair(mxv, mxv);
        send_pair(mn, mxv);               // largest span, already normalised
        send_pair(mxv, mn);
        send_offset(o, 1, 0, 0);          // unit axes, both signs
        send_offset(o, -1, 0, 0);
        send_offset(o, 0, 1, 0);
        send_offset(o, 0, -1, 0);
        send_offset(o, 0, 0, 1);
        send_offset(o, 0, 0, -1);
        send_offset(o, 256, 256, 256);
        send_offset(o, -256, 256, -256);
        send_offset(o, -1, 0, 1);
        send_offset(o, 1, 1, 0);
        send_offset(o, 3, 0, 0);          // small magnitude, needs left shift
        send_pair(mn, '{mxv[0], mn[1], mn[2]});
        send_pair(mxv, '{mn[0], mxv[1], mxv[2]});
        send_pair(mn, '{mn[0], mxv[1], mn[2]});
        send_offset(o, 8388607, -8388608, 1);
        end_burst();
    endtask

    task automatic test_random(input int count);
        logic signed [CW-1:0] c[3], n[3];
        for (int i = 0; i < count; i++) begin
            for (int k = 0; k < 3; k++) c[k] = rand_coord();
            if ($urandom_range(0, 19) == 0) n = c;
            else if ($urandom_range(0, 2) == 0)
                for (int k = 0; k < 3; k++)
                    n[k] = CW'(c[k] + $signed($urandom_range(0, 2000)) - 1000);
            else
                for (int k = 0; k < 3; k++) n[k] = rand_coord();
            send_pair(c, n);
        end
        end_burst();
    endtask

    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            begin
                int held;
                held = 0;
                while (held < 300) begin
                    @(posedge aclk);
                    held++;
                end
                sink_hold = 1'b0;
            end
            test_random(200);
        join
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (rot_queue.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        drain();                          // sender pauses until all results are in
        test_random(430);
        test_backpressure();
        drain();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        test_random(150);
        drain();
        repeat (LATENCY) @(posedge aclk);
        $display("Covered %0d results: coincident points, range extremes, axis directions,",
                 n_results);
        $display("random and near pairs, with idling and a long output stall.");
        if (n_errors == 0 && rot_queue.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dta_pkg.sv
rtl/core/dta_sqrt_cell.sv
rtl/core/dta_div_cell.sv
rtl/core/dta_cordic_cell.sv
rtl/core/direction_to_axis_angle.sv
rtl/core/dta_chk.sv
bench/tb_direction_to_axis_angle.sv
